[rtl/smf_pkg.sv]
// shared types for the sliding median filter
package smf_pkg;

    // flags one cell hands to its neighbours in the sorted chain
    typedef struct packed {
        logic gt;   // stored value is greater than the incoming sample
        logic del;  // the oldest entry sits in this cell or below it
    } t_cell_flags;

endpackage

[rtl/smf_cell.sv]
// one cell of the sorted window: a value with its age, kept in order with its neighbours
module smf_cell #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int AGE_WIDTH    = 4,
    parameter int LAST_AGE     = 10,
    parameter int RESET_AGE    = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] i_left_value,
    input  logic        [AGE_WIDTH-1:0]    i_left_age,
    input  smf_pkg::t_cell_flags           i_left_flags,
    input  logic signed [SAMPLE_WIDTH-1:0] i_right_value,
    input  logic        [AGE_WIDTH-1:0]    i_right_age,
    input  smf_pkg::t_cell_flags           i_right_flags,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output logic        [AGE_WIDTH-1:0]    o_age,
    output smf_pkg::t_cell_flags           o_flags
);

    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic signed [SAMPLE_WIDTH-1:0] n_value;
    logic        [AGE_WIDTH-1:0]    r_age;
    logic        [AGE_WIDTH-1:0]    n_age;
    logic                           gt;
    logic                           del;
    logic                           prev_gt;

    assign gt  = r_value > i_sample;
    assign del = i_left_flags.del | (r_age == AGE_WIDTH'(LAST_AGE));

    // greater-than flag of the entry just below once the oldest entry is gone
    assign prev_gt = i_left_flags.del ? gt : i_left_flags.gt;

    always_comb begin
        n_value = r_value;
        n_age   = r_age + AGE_WIDTH'(1);
        if (!del) begin
            // removal happens above: only the insertion shifts entries up
            if (gt) begin
                if (i_left_flags.gt) begin
                    n_value = i_left_value;
                    n_age   = i_left_age + AGE_WIDTH'(1);
                end else begin
                    n_value = i_sample;
                    n_age   = '0;
                end
            end
        end else if (!i_right_flags.gt) begin
            // removal at or below: close the gap from above
            n_value = i_right_value;
            n_age   = i_right_age + AGE_WIDTH'(1);
        end else if (prev_gt) begin
            if (!i_left_flags.del) begin
                n_value = i_left_value;
                n_age   = i_left_age + AGE_WIDTH'(1);
            end
        end else begin
            n_value = i_sample;
            n_age   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_age   <= AGE_WIDTH'(RESET_AGE);
        end else if (i_en) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_value     = r_value;
    assign o_age       = r_age;
    assign o_flags.gt  = gt;
    assign o_flags.del = del;

endmodule

[rtl/sliding_median_filter.sv]
// sliding window median filter built from a sorted chain of cells
// Each accepted sample replaces the oldest of the last WINDOW_LENGTH samples and the block
// returns the median of the window (the element at position WINDOW_LENGTH/2 in ascending
// order, the upper middle one for an even length). The window starts as all zeros after
// reset, so early results count those zeros as samples. One sample is taken every cycle
// unless the output stalls; the result is ready in the cycle after its input transfer
// and is read from the middle cell. The cycle time is set by the one-bit oldest-entry flag
// that ripples through all WINDOW_LENGTH cells alongside one sample-wide compare per cell.
module sliding_median_filter #(
    parameter int WINDOW_LENGTH = 11,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_median
);

    localparam int AGE_WIDTH = $clog2(WINDOW_LENGTH);
    localparam int MID       = WINDOW_LENGTH / 2;

    logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW_LENGTH];
    logic        [AGE_WIDTH-1:0]    cell_age   [WINDOW_LENGTH];
    smf_pkg::t_cell_flags           cell_flags [WINDOW_LENGTH];
    logic                           r_out_valid;
    logic                           in_xfer;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_xfer    = i_in_valid & ~o_in_stall;

    for (genvar g = 0; g < WINDOW_LENGTH; g++) begin : g_cell
        logic signed [SAMPLE_WIDTH-1:0] left_value;
        logic        [AGE_WIDTH-1:0]    left_age;
        smf_pkg::t_cell_flags           left_flags;
        logic signed [SAMPLE_WIDTH-1:0] right_value;
        logic        [AGE_WIDTH-1:0]    right_age;
        smf_pkg::t_cell_flags           right_flags;

        if (g == 0) begin : g_bottom
            assign left_value = '0;
            assign left_age   = '0;
            assign left_flags = '{gt: 1'b0, del: 1'b0};
        end else begin : g_left
            assign left_value = cell_value[g-1];
            assign left_age   = cell_age[g-1];
            assign left_flags = cell_flags[g-1];
        end

        // beyond the top the shortened list acts as larger than any sample
        if (g == WINDOW_LENGTH - 1) begin : g_top
            assign right_value = '0;
            assign right_age   = '0;
            assign right_flags = '{gt: 1'b1, del: 1'b1};
        end else begin : g_right
            assign right_value = cell_value[g+1];
            assign right_age   = cell_age[g+1];
            assign right_flags = cell_flags[g+1];
        end

        smf_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_WIDTH    (AGE_WIDTH),
            .LAST_AGE     (WINDOW_LENGTH - 1),
            .RESET_AGE    (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (in_xfer),
            .i_sample      (i_sample),
            .i_left_value  (left_value),
            .i_left_age    (left_age),
            .i_left_flags  (left_flags),
            .i_right_value (right_value),
            .i_right_age   (right_age),
            .i_right_flags (right_flags),
            .o_value       (cell_value[g]),
            .o_age         (cell_age[g]),
            .o_flags       (cell_flags[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_median    = cell_value[MID];

endmodule
